@@ rtl/qn_pkg.sv @@
// Package for the quaternion normalizer: transaction payload types.
// No dependencies.
`default_nettype none

package qn_pkg;

    // Fixed field width of every component, Q1.14 in the default build
    localparam int unsigned COMP_W = 16;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
        logic signed [COMP_W-1:0] comp_w;
    } quat_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic signed [COMP_W-1:0] unit_w;
        logic                     zero_length;
    } quat_out_t;

endpackage

`default_nettype wire

@@ rtl/quaternion_normalize.sv @@
// Quaternion normalizer top level: scales four components to unit length.
// Depends on qn_pkg.
`default_nettype none

// Accepts one quaternion per clock (busy is always low) and returns it on
// result with a one-cycle done strobe; the receiver cannot stall. The
// pipeline holds the reciprocal square root search, one pipeline stage per
// result bit (FRAC_BITS + 1 stages), plus input capture, squaring, summing
// and output stages. Each output is round(c * 2^FRAC_BITS / sqrt(S)), ties
// away from zero, saturated to 16 bits. An all-zero quaternion passes
// through with zero_length set.
module quaternion_normalize #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire qn_pkg::quat_in_t  item,
    output logic                   done,
    output qn_pkg::quat_out_t      result
);
    import qn_pkg::*;

    localparam int unsigned NW = FRAC_BITS + 1;          // result bits
    localparam int unsigned W  = 2 * FRAC_BITS + 38;     // search datapath
    localparam int unsigned CW = (NW > 17) ? NW : 17;    // saturation compare
    localparam int unsigned SH = 2 * FRAC_BITS + 2;

    // ------------------------------------------------------------------
    // Stage A: capture
    logic                   a_vld_reg;
    logic signed [15:0]     a_comp_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_comp_reg[0] <= item.comp_x;
        a_comp_reg[1] <= item.comp_y;
        a_comp_reg[2] <= item.comp_z;
        a_comp_reg[3] <= item.comp_w;
    end

    // ------------------------------------------------------------------
    // Stage B: magnitudes and squares
    logic               b_vld_reg;
    logic [30:0]        b_sq_reg  [4];
    logic               b_neg_reg [4];
    logic [16:0]        mag_a     [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag_a[i] = a_comp_reg[i][15] ? (17'h10000 - {1'b0, a_comp_reg[i]})
                                         : {1'b0, a_comp_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            b_sq_reg[i]  <= 31'(mag_a[i] * mag_a[i]);
            b_neg_reg[i] <= a_comp_reg[i][15];
        end
    end

    // ------------------------------------------------------------------
    // Search pipeline arrays: index 0 is loaded by stage C
    logic                 vld_reg  [NW+1];
    logic                 zero_reg [NW+1];
    logic signed [W-1:0]  s_reg    [NW+1];
    logic signed [W-1:0]  r_reg    [NW+1][4];
    logic signed [W-1:0]  p_reg    [NW+1][4];
    logic signed [W-1:0]  q_reg    [NW+1][4];
    logic [NW-1:0]        n_reg    [NW+1][4];
    logic                 neg_reg  [NW+1][4];

    // Stage C: sum of squares, target R = a^2 * 2^SH, start at m = -1
    logic [32:0] sum_b;
    assign sum_b = 33'(b_sq_reg[0]) + 33'(b_sq_reg[1])
                 + 33'(b_sq_reg[2]) + 33'(b_sq_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (sum_b == 33'd0);
        s_reg[0]    <= $signed({{(W-33){1'b0}}, sum_b});
        for (int i = 0; i < 4; i++)
        begin
            r_reg[0][i]   <= $signed({{(W-31){1'b0}}, b_sq_reg[i]}) <<< SH;
            p_reg[0][i]   <= $signed({{(W-33){1'b0}}, sum_b});
            q_reg[0][i]   <= -$signed({{(W-33){1'b0}}, sum_b});
            n_reg[0][i]   <= '0;
            neg_reg[0][i] <= b_neg_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // One stage per result bit, MSB first. With m = 2n - 1, P = m^2 * S and
    // Q = m * S are kept so that setting bit k needs only shifted adds.
    for (genvar j = 0; j < NW; j++)
    begin : g_bit
        localparam int unsigned K = NW - 1 - j;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            logic signed [W-1:0] cand;
            logic                take;

            assign cand = p_reg[j][l] + (q_reg[j][l] <<< (K + 2))
                        + (s_reg[j] <<< (2 * K + 2));
            assign take = (cand <= r_reg[j][l]);

            always_ff @(posedge clk)
            begin
                r_reg[j+1][l]   <= r_reg[j][l];
                neg_reg[j+1][l] <= neg_reg[j][l];
                p_reg[j+1][l]   <= take ? cand : p_reg[j][l];
                q_reg[j+1][l]   <= take ? (q_reg[j][l] + (s_reg[j] <<< (K + 1)))
                                        : q_reg[j][l];
                n_reg[j+1][l]   <= n_reg[j][l] | (take ? (NW'(1) << K) : '0);
            end
        end

        always_ff @(posedge clk)
        begin
            s_reg[j+1]    <= s_reg[j];
            zero_reg[j+1] <= zero_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign, saturation, zero-length override
    logic [15:0] unit_o [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [CW-1:0] nx;
            logic [15:0]   sat;
            nx  = CW'(n_reg[NW][i]);
            sat = '0;
            if (zero_reg[NW])
            begin
                unit_o[i] = '0;
            end
            else if (neg_reg[NW][i])
            begin
                sat       = (nx >= CW'(32768)) ? 16'h8000 : nx[15:0];
                unit_o[i] = 16'(17'h10000 - {1'b0, sat});
            end
            else
            begin
                sat       = (nx > CW'(32767)) ? 16'h7FFF : nx[15:0];
                unit_o[i] = sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= vld_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        result.unit_x      <= unit_o[0];
        result.unit_y      <= unit_o[1];
        result.unit_z      <= unit_o[2];
        result.unit_w      <= unit_o[3];
        result.zero_length <= zero_reg[NW];
    end

    // Fully pipelined, never refuses a transaction
    assign busy = 1'b0;

endmodule

`default_nettype wire

@@ tb/quaternion_normalize_tb.sv @@
// Self-checking testbench for quaternion_normalize: directed table then random quaternions.
// Depends on qn_pkg and the quaternion_normalize RTL; results checked against a local predictor.
`timescale 1ns / 100ps

module quaternion_normalize_tb;
    import qn_pkg::*;

    localparam int unsigned FRAC = 14;
    localparam int unsigned LATENCY = FRAC + 5;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned DIRECTED_ROWS = 16;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    quat_in_t  item;
    logic      done;
    quat_out_t result;

    quat_out_t unit_queue[$];
    int        error_count;
    int        stall_count;
    bit        stim_done;

    quaternion_normalize #(.FRAC_BITS(FRAC)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Nearest integer to a * 2^FRAC / sqrt(s), ties away from zero
    function automatic longint unsigned scaled_mag(longint unsigned a, longint unsigned s);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        rhs = 128'(a * a) << (2 * FRAC + 2);
        lo = 0;
        hi = 64'd1 << FRAC;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(s);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic quat_out_t normalize_quat(quat_in_t q);
        logic signed [15:0] c[4];
        longint unsigned    mag[4];
        longint unsigned    s;
        longint unsigned    n;
        logic signed [15:0] u[4];
        quat_out_t          r;
        c[0] = q.comp_x;
        c[1] = q.comp_y;
        c[2] = q.comp_z;
        c[3] = q.comp_w;
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = c[i][15] ? 64'(-32'(c[i])) : 64'(c[i]);
            s += mag[i] * mag[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            if (s == 0)
                u[i] = '0;
            else
            begin
                n = scaled_mag(mag[i], s);
                if (c[i][15])
                begin
                    if (n > 32768) n = 32768;
                    u[i] = 16'(-n);
                end
                else
                begin
                    if (n > 32767) n = 32767;
                    u[i] = 16'(n);
                end
            end
        end
        r.unit_x = u[0];
        r.unit_y = u[1];
        r.unit_z = u[2];
        r.unit_w = u[3];
        r.zero_length = (s == 0);
        return r;
    endfunction

    // Directed rows; expected value typed only where obvious
    typedef struct {
        quat_in_t  q;
        bit        has_fixed;
        quat_out_t fixed;
    } dir_row_t;

    dir_row_t dir_table[DIRECTED_ROWS];

    initial
    begin
        dir_table[0]  = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}};
        dir_table[1]  = '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
        dir_table[2]  = '{'{16'sd0, -16'sd1, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0}};
        dir_table[3]  = '{'{16'sd0, 16'sd0, -16'sd32768, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0}};
        dir_table[4]  = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0}};
        dir_table[5]  = '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
        dir_table[6]  = '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b1, '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0}};
        dir_table[7]  = '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b1, '{-16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192, 1'b0}};
        dir_table[8]  = '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b1, '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0}};
        dir_table[9]  = '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0};
        dir_table[10] = '{'{16'sd3, 16'sd4, 16'sd0, 16'sd0}, 1'b0, '0};
        dir_table[11] = '{'{16'sd1, 16'sd1, 16'sd0, 16'sd0}, 1'b0, '0};
        dir_table[12] = '{'{16'sd1, 16'sd2, 16'sd2, 16'sd4}, 1'b0, '0};
        dir_table[13] = '{'{16'sd32767, 16'sd1, 16'sd0, 16'sd0}, 1'b0, '0};
        dir_table[14] = '{'{-16'sd1, 16'sd32767, -16'sd2, 16'sd5}, 1'b0, '0};
        dir_table[15] = '{'{16'sd11585, -16'sd11585, 16'sd0, 16'sd0}, 1'b0, '0};
    end

    // Random quaternion with a spread of magnitudes
    function automatic quat_in_t random_quat();
        quat_in_t q;
        logic [15:0] v[4];
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 4))
                0: v[i] = 16'($urandom_range(0, 7)) - 16'd3;
                1: v[i] = 16'(signed'(17'($urandom_range(0, 511)) - 17'sd256));
                2: v[i] = 16'h0;
                default: v[i] = 16'($urandom);
            endcase
        end
        q.comp_x = v[0];
        q.comp_y = v[1];
        q.comp_z = v[2];
        q.comp_w = v[3];
        return q;
    endfunction

    // Present one transaction, wait for acceptance, then drop start unless next follows
    task automatic send_quat(quat_in_t q, quat_out_t expected);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item  <= q;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        unit_queue.push_back(expected);
        @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        quat_in_t q;
        start = 1'b0;
        item  = '0;
        rst_n = 1'b0;
        stim_done = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_quat(dir_table[i].q,
                dir_table[i].has_fixed ? dir_table[i].fixed : normalize_quat(dir_table[i].q));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // hold off once until the pipeline drains
            if (i == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                while (unit_queue.size() != 0)
                    @(negedge clk);
            end
            q = random_quat();
            send_quat(q, normalize_quat(q));
        end
        start <= 1'b0;
        stim_done = 1'b1;
    end

    // Result checking
    always @(posedge clk)
    begin
        quat_out_t want;
        if (rst_n && done)
        begin
            if (unit_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected result %h", result);
            end
            else
            begin
                want = unit_queue.pop_front();
                if (result.unit_x !== want.unit_x || result.unit_y !== want.unit_y ||
                    result.unit_z !== want.unit_z || result.unit_w !== want.unit_w ||
                    result.zero_length !== want.zero_length)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: expected x=%0d y=%0d z=%0d w=%0d zl=%0b got x=%0d y=%0d z=%0d w=%0d zl=%0b",
                            want.unit_x, want.unit_y, want.unit_z, want.unit_w, want.zero_length,
                            result.unit_x, result.unit_y, result.unit_z, result.unit_w,
                            result.zero_length);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    // End of run
    initial
    begin
        error_count = 0;
        stall_count = 0;
        fork
            begin
                wait (stim_done);
                while (unit_queue.size() != 0)
                    @(posedge clk);
                repeat (LATENCY + 4) @(posedge clk);
            end
            begin
                @(posedge clk);
                while (stall_count < WATCHDOG_LIMIT)
                    @(posedge clk);
                error_count++;
            end
        join_any
        if (unit_queue.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
